### rtl/ptld_pkg.sv
`default_nettype none
package ptld_pkg;
  localparam int COORD_W = 24;
  localparam int DIR_W   = 16;
  localparam int DIST_W  = 26;
  localparam int V_W     = COORD_W + 1;
  localparam int PROD_W  = DIR_W + V_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = PROD_W;
  localparam int LO_W    = (MAG_W + 1) / 2;
  localparam int HI_W    = MAG_W - LO_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int NUM_W   = SQ_W + 2;
  localparam int DEN_W   = 2 * DIR_W;
  localparam int T_W     = DIST_W + DEN_W;
  localparam int ACC_W   = T_W + DIST_W + 2;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [DIR_W-1:0]   dir_x;
    logic signed [DIR_W-1:0]   dir_y;
    logic signed [DIR_W-1:0]   dir_z;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              zero_direction;
  } out_t;

  typedef struct packed {
    logic [ACC_W-1:0]  rem;
    logic [T_W-1:0]    t;
    logic [DEN_W-1:0]  den;
    logic [DIST_W-1:0] r;
    logic              zero;
  } root_t;
endpackage
`default_nettype wire

### rtl/ptld_front.sv
`default_nettype none
module ptld_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           in_vld,
  input  wire ptld_pkg::in_t  in_item,
  output logic                out_vld,
  output ptld_pkg::root_t     out_item
);
  import ptld_pkg::*;

  // stage 1: v = p - o
  logic                       v1;
  logic signed [V_W-1:0]      vx1, vy1, vz1;
  logic signed [DIR_W-1:0]    dx1, dy1, dz1;
  // stage 2: products
  logic                       v2;
  logic signed [PROD_W-1:0]   p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;
  logic [DEN_W-1:0]           sqx, sqy, sqz;
  logic signed [V_W-1:0]      vx2, vy2, vz2;
  // stage 3: magnitudes
  logic                       v3;
  logic [MAG_W-1:0]           mag3 [3];
  logic [DEN_W-1:0]           den3;
  logic                       zero3;
  // stage 4: partial products
  logic                       v4;
  logic [2*HI_W-1:0]          hh4 [3];
  logic [HI_W+LO_W-1:0]       hl4 [3];
  logic [2*LO_W-1:0]          ll4 [3];
  logic [DEN_W-1:0]           den4;
  logic                       zero4;

  logic signed [CROSS_W-1:0]  cx, cy, cz;
  logic [DEN_W-1:0]           den_sum;
  logic [MAG_W-1:0]           mag_next [3];
  logic [NUM_W-1:0]           num_next;

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [CROSS_W-1:0] a);
    logic signed [CROSS_W-1:0] n;
    n = (a < 0) ? -a : a;
    return n[MAG_W-1:0];
  endfunction

  always_comb begin
    cx = CROSS_W'(p_yz) - CROSS_W'(p_zy);
    cy = CROSS_W'(p_zx) - CROSS_W'(p_xz);
    cz = CROSS_W'(p_xy) - CROSS_W'(p_yx);
    den_sum = sqx + sqy + sqz;
    if (den_sum == '0) begin
      mag_next[0] = mag_of(CROSS_W'(vx2));
      mag_next[1] = mag_of(CROSS_W'(vy2));
      mag_next[2] = mag_of(CROSS_W'(vz2));
    end else begin
      mag_next[0] = mag_of(cx);
      mag_next[1] = mag_of(cy);
      mag_next[2] = mag_of(cz);
    end
    num_next = '0;
    for (int i = 0; i < 3; i++) begin
      num_next = num_next + NUM_W'((SQ_W'(hh4[i]) << (2 * LO_W))
                                   + (SQ_W'(hl4[i]) << (LO_W + 1))
                                   + SQ_W'(ll4[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_vld <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx1 <= V_W'(in_item.point_x) - V_W'(in_item.origin_x);
      vy1 <= V_W'(in_item.point_y) - V_W'(in_item.origin_y);
      vz1 <= V_W'(in_item.point_z) - V_W'(in_item.origin_z);
      dx1 <= in_item.dir_x;
      dy1 <= in_item.dir_y;
      dz1 <= in_item.dir_z;

      p_yz <= PROD_W'(dy1) * PROD_W'(vz1);
      p_zy <= PROD_W'(dz1) * PROD_W'(vy1);
      p_zx <= PROD_W'(dz1) * PROD_W'(vx1);
      p_xz <= PROD_W'(dx1) * PROD_W'(vz1);
      p_xy <= PROD_W'(dx1) * PROD_W'(vy1);
      p_yx <= PROD_W'(dy1) * PROD_W'(vx1);
      sqx  <= DEN_W'(dx1 * dx1);
      sqy  <= DEN_W'(dy1 * dy1);
      sqz  <= DEN_W'(dz1 * dz1);
      vx2  <= vx1;
      vy2  <= vy1;
      vz2  <= vz1;

      mag3  <= mag_next;
      zero3 <= (den_sum == '0);
      den3  <= (den_sum == '0) ? DEN_W'(1) : den_sum;

      for (int i = 0; i < 3; i++) begin
        hh4[i] <= mag3[i][MAG_W-1:LO_W] * mag3[i][MAG_W-1:LO_W];
        hl4[i] <= mag3[i][MAG_W-1:LO_W] * mag3[i][LO_W-1:0];
        ll4[i] <= mag3[i][LO_W-1:0] * mag3[i][LO_W-1:0];
      end
      den4  <= den3;
      zero4 <= zero3;

      out_item.rem  <= ACC_W'(num_next);
      out_item.t    <= '0;
      out_item.den  <= den4;
      out_item.r    <= '0;
      out_item.zero <= zero4;
    end
  end
endmodule
`default_nettype wire

### rtl/ptld_root_step.sv
`default_nettype none
module ptld_root_step #(
  parameter int BIT = 0
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_vld,
  input  wire ptld_pkg::root_t in_item,
  output logic                 out_vld,
  output ptld_pkg::root_t      out_item
);
  import ptld_pkg::*;

  logic [ACC_W-1:0] delta;
  logic             take;
  root_t            item_next;

  // (r + 2^b)^2 den - r^2 den = (2 r den + 2^b den) 2^b
  always_comb begin
    delta = ((ACC_W'(in_item.t) << 1) + (ACC_W'(in_item.den) << BIT)) << BIT;
    take  = (delta <= in_item.rem);
    item_next = in_item;
    if (take) begin
      item_next.rem    = in_item.rem - delta;
      item_next.t      = in_item.t + (T_W'(in_item.den) << BIT);
      item_next.r[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end
endmodule
`default_nettype wire

### rtl/point_to_line_distance_3d.sv
// Pipeline: 5 front stages followed by 26 root stages, from input beat to output beat.
// Throughput: one beat per cycle; the whole pipeline holds while out_ready is low
// and a result is waiting.
// Reset (rst, synchronous): clears all stage valid bits; no pending beats remain.
`default_nettype none
module point_to_line_distance_3d (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire ptld_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output ptld_pkg::out_t      out_data
);
  import ptld_pkg::*;

  logic  en;
  logic  vld [DIST_W+1];
  root_t stg [DIST_W+1];

  assign en       = out_ready || !out_valid;
  assign in_ready = en;

  ptld_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (in_valid),
    .in_item  (in_data),
    .out_vld  (vld[0]),
    .out_item (stg[0])
  );

  for (genvar k = 0; k < DIST_W; k++) begin : g_root
    ptld_root_step #(.BIT(DIST_W - 1 - k)) u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_vld   (vld[k]),
      .in_item  (stg[k]),
      .out_vld  (vld[k+1]),
      .out_item (stg[k+1])
    );
  end

  assign out_valid               = vld[DIST_W];
  assign out_data.distance       = stg[DIST_W].r;
  assign out_data.zero_direction = stg[DIST_W].zero;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
  a_zero_den: assert property (@(posedge clk) disable iff (rst)
    vld[0] && stg[0].zero |-> stg[0].den == DEN_W'(1))
    else $error("zero direction without unit divisor");
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    vld[0] |-> stg[0].den != '0)
    else $error("zero divisor entered root pipeline");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld[0]) && $stable(stg[0]))
    else $error("front stage moved while stalled");
endmodule
`default_nettype wire

### dv/ptld_checker.sv
`default_nettype none
module ptld_checker (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic           in_ready,
  input  wire ptld_pkg::in_t  in_data,
  input  wire logic           out_valid,
  input  wire logic           out_ready,
  input  wire ptld_pkg::out_t out_data,
  output int                  fails,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import ptld_pkg::*;

  out_t expected_dist[$];

  function automatic logic [127:0] mag_sq(longint x);
    logic [127:0] m;
    m = (x < 0) ? 128'(-x) : 128'(x);
    return m * m;
  endfunction

  function automatic out_t predict_distance(in_t q);
    longint vx, vy, vz, dx, dy, dz, cx, cy, cz;
    logic [127:0] num, den, cand;
    logic [DIST_W-1:0] r;
    out_t res;
    dx = longint'(q.dir_x);
    dy = longint'(q.dir_y);
    dz = longint'(q.dir_z);
    vx = longint'(q.point_x) - longint'(q.origin_x);
    vy = longint'(q.point_y) - longint'(q.origin_y);
    vz = longint'(q.point_z) - longint'(q.origin_z);
    den = 128'(dx * dx + dy * dy + dz * dz);
    res.zero_direction = (den == 0);
    if (den == 0) begin
      num = mag_sq(vx) + mag_sq(vy) + mag_sq(vz);
      den = 1;
    end else begin
      cx = dy * vz - dz * vy;
      cy = dz * vx - dx * vz;
      cz = dx * vy - dy * vx;
      num = mag_sq(cx) + mag_sq(cy) + mag_sq(cz);
    end
    r = '0;
    for (int b = DIST_W - 1; b >= 0; b--) begin
      cand = 128'(r) | (128'(1) << b);
      if (cand * cand * den <= num) r = cand[DIST_W-1:0];
    end
    res.distance = r;
    return res;
  endfunction

  assign pending = expected_dist.size();

  initial fails = 0;

  always @(posedge clk) begin
    out_t exp_r;
    if (!rst) begin
      if (in_valid && in_ready) expected_dist.push_back(predict_distance(in_data));
      if (out_valid && out_ready) begin
        if (expected_dist.size() == 0) begin
          fails <= fails + 1;
          if (fails < 10) $display("unexpected result beat: distance=%0d zero=%0b",
                                   out_data.distance, out_data.zero_direction);
        end else begin
          exp_r = expected_dist.pop_front();
          if (exp_r.distance !== out_data.distance ||
              exp_r.zero_direction !== out_data.zero_direction) begin
            fails <= fails + 1;
            if (fails < 10)
              $display("mismatch: distance exp=%0d got=%0d, zero exp=%0b got=%0b",
                       exp_r.distance, out_data.distance,
                       exp_r.zero_direction, out_data.zero_direction);
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

### dv/point_to_line_distance_3d_tb.sv
`default_nettype none
module point_to_line_distance_3d_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptld_pkg::*;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  in_t  in_data;
  out_t out_data;
  int   fails, pending;
  int   cycles;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int N_RANDOM = 2000;

  point_to_line_distance_3d DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  ptld_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fails(fails), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return COORD_W'($urandom);
      1: return COORD_W'($signed($urandom_range(0, 512)) - 256);
      2: return $urandom_range(0, 1) ? {1'b0, {(COORD_W-1){1'b1}}} : {1'b1, {(COORD_W-1){1'b0}}};
      default: return COORD_W'($signed($urandom_range(0, 200000)) - 100000);
    endcase
  endfunction

  function automatic logic [DIR_W-1:0] rand_dir();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return DIR_W'($signed($urandom_range(0, 8)) - 4);
      2: return $urandom_range(0, 1) ? {1'b0, {(DIR_W-1){1'b1}}} : {1'b1, {(DIR_W-1){1'b0}}};
      default: return DIR_W'($urandom);
    endcase
  endfunction

  function automatic in_t rand_query();
    in_t q;
    int k;
    q.origin_x = rand_coord(); q.origin_y = rand_coord(); q.origin_z = rand_coord();
    q.point_x = rand_coord(); q.point_y = rand_coord(); q.point_z = rand_coord();
    case ($urandom_range(0, 9))
      0: begin q.dir_x = '0; q.dir_y = '0; q.dir_z = '0; end
      1: begin
        // point on the line
        q.dir_x = DIR_W'($signed($urandom_range(0, 200)) - 100);
        q.dir_y = DIR_W'($signed($urandom_range(0, 200)) - 100);
        q.dir_z = DIR_W'($signed($urandom_range(0, 200)) - 100);
        k = $signed($urandom_range(0, 2000)) - 1000;
        q.origin_x = COORD_W'($signed($urandom_range(0, 2000000)) - 1000000);
        q.origin_y = COORD_W'($signed($urandom_range(0, 2000000)) - 1000000);
        q.origin_z = COORD_W'($signed($urandom_range(0, 2000000)) - 1000000);
        q.point_x = q.origin_x + COORD_W'(k * q.dir_x);
        q.point_y = q.origin_y + COORD_W'(k * q.dir_y);
        q.point_z = q.origin_z + COORD_W'(k * q.dir_z);
      end
      default: begin q.dir_x = rand_dir(); q.dir_y = rand_dir(); q.dir_z = rand_dir(); end
    endcase
    return q;
  endfunction

  task automatic send_query(in_t q, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= q;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic int draw_gap(bit busy);
    if (busy) return 0;
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
  endfunction

  initial begin
    int g;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      g = (cycles % 3000 < 500) ? 0 : draw_gap(1'b0);
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    in_t q;
    logic [COORD_W-1:0] cmax, cmin;
    logic [DIR_W-1:0] dmax, dmin;
    cycles = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cmax = {1'b0, {(COORD_W-1){1'b1}}};
    cmin = {1'b1, {(COORD_W-1){1'b0}}};
    dmax = {1'b0, {(DIR_W-1){1'b1}}};
    dmin = {1'b1, {(DIR_W-1){1'b0}}};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_query('0, 0);
    q = '0; q.point_x = cmax; q.origin_x = cmin; send_query(q, 0);
    q = '0; q.point_x = cmin; q.point_y = cmin; q.point_z = cmin;
    q.origin_x = cmax; q.origin_y = cmax; q.origin_z = cmax; send_query(q, 2);
    q.dir_x = dmax; q.dir_y = dmin; q.dir_z = dmax; send_query(q, 0);
    q.dir_x = dmin; q.dir_y = dmin; q.dir_z = dmin; send_query(q, 1);
    q.dir_x = dmin; q.dir_y = dmax; q.dir_z = '0; send_query(q, 0);
    q = '0; q.dir_x = 1; q.point_x = 1000; send_query(q, 0);
    q = '0; q.dir_x = 1; q.point_y = 256; send_query(q, 3);
    q = '0; q.dir_z = dmin; q.point_x = cmax; q.point_y = cmin; send_query(q, 0);
    q = '0; q.dir_y = -1; q.point_x = 1; send_query(q, 0);
    q = '0; q.point_x = 3; q.point_y = 4; send_query(q, 0);
    q = '0; q.dir_x = 2; q.dir_y = 2; q.dir_z = 2;
    q.point_x = 50; q.point_y = 50; q.point_z = 50; send_query(q, 0);
    q = '0; q.dir_x = dmax; q.dir_y = 1; q.point_x = cmin; q.point_z = cmax; send_query(q, 5);
    q = '0; q.origin_x = cmax; q.origin_y = cmax; q.origin_z = cmax;
    q.point_x = cmax; q.point_y = cmax; q.point_z = cmax; q.dir_x = dmax; send_query(q, 0);
    q = '0; q.origin_x = -1; q.origin_y = -1; q.origin_z = -1; q.dir_y = 1; send_query(q, 0);

    for (int i = 0; i < N_RANDOM; i++)
      send_query(rand_query(), draw_gap((i % 400) < 60));
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

### point_to_line_distance_3d.f
rtl/ptld_pkg.sv
rtl/ptld_front.sv
rtl/ptld_root_step.sv
rtl/point_to_line_distance_3d.sv
dv/ptld_checker.sv
dv/point_to_line_distance_3d_tb.sv
